// ===== src/optt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the one-shot and periodic timer table.
// Holds the table size, request and result codes, and the controller/datapath structs.
package optt_pkg;

   localparam int NUM_TIMERS = 16;
   localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);
   localparam int IV_W       = 24;
   localparam int TAG_W      = 16;
   localparam int ID_IN_W    = 8;
   localparam int ID_OUT_W   = 6;
   localparam int TICK_W     = 16;

   typedef enum logic [1:0] {
      REQ_ONESHOT  = 2'd0,
      REQ_PERIODIC = 2'd1,
      REQ_CANCEL   = 2'd2,
      REQ_TICK     = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_CREATED     = 3'd0,
      ST_CREATE_FAIL = 3'd1,
      ST_CANCELLED   = 3'd2,
      ST_NOT_FOUND   = 3'd3,
      ST_FIRED       = 3'd4,
      ST_TICK_DONE   = 3'd5
   } rsp_status_type;

   typedef struct packed {
      logic create;
      logic cancel;
      logic tick_begin;
      logic step;
      logic finish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic enable;
      logic used_zero;
      logic walk_last;
   } dp_stat_type;

endpackage

// ===== src/optt_ctrl.sv =====
`timescale 1ns / 1ps
// Controller for the timer table: sequences create, cancel and tick walks.
// Depends on optt_pkg for codes and the command/status structs.
module optt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_type,
   input  optt_pkg::dp_stat_type stat,
   output logic                  busy,
   output optt_pkg::ctrl_cmd_type cmd
);
   import optt_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_type == REQ_ONESHOT || req_type == REQ_PERIODIC) begin
                  cmd.create = 1'b1;
               end else if (req_type == REQ_CANCEL) begin
                  cmd.cancel = 1'b1;
               end else begin
                  cmd.tick_begin = 1'b1;
                  if (stat.enable && !stat.used_zero) begin
                     state_in = S_WALK;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_WALK: begin
            cmd.step = 1'b1;
            if (stat.walk_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/optt_dp.sv =====
`timescale 1ns / 1ps
// Datapath for the timer table: slot storage, enable register and result register.
// Depends on optt_pkg; driven by optt_ctrl commands.
module optt_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  optt_pkg::ctrl_cmd_type            cmd,
   output optt_pkg::dp_stat_type             stat,
   input  logic [1:0]                        req_type,
   input  logic [optt_pkg::IV_W-1:0]         req_interval_ms,
   input  logic [optt_pkg::TAG_W-1:0]        req_callback_tag,
   input  logic [optt_pkg::ID_IN_W-1:0]      req_timer_id,
   input  logic [optt_pkg::TICK_W-1:0]       req_tick_ms,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_enable,
   output logic                              rsp_strobe,
   output logic [2:0]                        rsp_status,
   output logic [optt_pkg::ID_OUT_W-1:0]     rsp_timer_id_res,
   output logic [optt_pkg::TAG_W-1:0]        rsp_callback_tag_res,
   output logic                              rsp_last
);
   import optt_pkg::*;

   logic [NUM_TIMERS-1:0] active_ff;
   logic [NUM_TIMERS-1:0] periodic_ff;
   logic [IV_W-1:0]       interval_ff [NUM_TIMERS];
   logic [IV_W-1:0]       elapsed_ff  [NUM_TIMERS];
   logic [TAG_W-1:0]      tag_ff      [NUM_TIMERS];
   logic [CNT_W-1:0]      used_ff;
   logic                  enable_ff;
   logic [IDX_W-1:0]      walk_ff;
   logic [TICK_W-1:0]     tick_ff;

   logic                  rsp_valid_ff;
   rsp_status_type        rsp_status_ff;
   logic [ID_OUT_W-1:0]   rsp_id_ff;
   logic [TAG_W-1:0]      rsp_tag_ff;
   logic                  rsp_last_ff;

   logic                  table_full;
   logic [IDX_W-1:0]      new_slot;
   logic [CNT_W-1:0]      used_inc;
   logic [ID_IN_W-1:0]    id_minus;
   logic [IDX_W-1:0]      cancel_slot;
   logic                  id_found;
   logic [CNT_W-1:0]      walk_inc;
   logic [IV_W:0]         sum;
   logic [IV_W-1:0]       elapsed_sat;
   logic                  fire;

   assign csr_ready  = 1'b1;
   assign table_full = (used_ff == CNT_W'(NUM_TIMERS));
   assign new_slot   = used_ff[IDX_W-1:0];
   assign used_inc   = used_ff + CNT_W'(1);
   assign id_minus   = req_timer_id - ID_IN_W'(1);
   assign cancel_slot = id_minus[IDX_W-1:0];
   assign id_found   = (req_timer_id != '0) &&
                       (req_timer_id <= ID_IN_W'(used_ff));
   assign walk_inc   = CNT_W'(walk_ff) + CNT_W'(1);

   assign sum         = {1'b0, elapsed_ff[walk_ff]} + (IV_W+1)'(tick_ff);
   assign elapsed_sat = sum[IV_W] ? '1 : sum[IV_W-1:0];
   assign fire        = active_ff[walk_ff] && (elapsed_sat >= interval_ff[walk_ff]);

   assign stat.enable    = enable_ff;
   assign stat.used_zero = (used_ff == '0);
   assign stat.walk_last = (walk_inc == used_ff);

   // slot storage
   always_ff @(posedge clock) begin
      if (cmd.create && enable_ff && !table_full) begin
         periodic_ff[new_slot] <= (req_type == REQ_PERIODIC);
         interval_ff[new_slot] <= req_interval_ms;
         elapsed_ff[new_slot]  <= '0;
         tag_ff[new_slot]      <= req_callback_tag;
      end else if (cmd.step && active_ff[walk_ff]) begin
         if (fire && periodic_ff[walk_ff]) begin
            elapsed_ff[walk_ff] <= '0;
         end else begin
            elapsed_ff[walk_ff] <= elapsed_sat;
         end
      end
      if (cmd.tick_begin) begin
         tick_ff <= req_tick_ms;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         used_ff   <= '0;
         enable_ff <= 1'b1;
         walk_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            enable_ff <= csr_enable;
         end
         if (cmd.create && enable_ff && !table_full) begin
            active_ff[new_slot] <= 1'b1;
            used_ff             <= used_inc;
         end
         if (cmd.cancel && id_found) begin
            active_ff[cancel_slot] <= 1'b0;
         end
         if (cmd.tick_begin) begin
            walk_ff <= '0;
         end else if (cmd.step) begin
            if (fire && !periodic_ff[walk_ff]) begin
               active_ff[walk_ff] <= 1'b0;
            end
            walk_ff <= walk_inc[IDX_W-1:0];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.create || cmd.cancel || cmd.finish || (cmd.step && fire);
      end
      rsp_tag_ff  <= '0;
      rsp_id_ff   <= '0;
      rsp_last_ff <= 1'b1;
      if (cmd.create) begin
         if (enable_ff && !table_full) begin
            rsp_status_ff <= ST_CREATED;
            rsp_id_ff     <= ID_OUT_W'(used_inc);
         end else begin
            rsp_status_ff <= ST_CREATE_FAIL;
         end
      end else if (cmd.cancel) begin
         if (id_found) begin
            rsp_status_ff <= ST_CANCELLED;
            rsp_id_ff     <= req_timer_id[ID_OUT_W-1:0];
         end else begin
            rsp_status_ff <= ST_NOT_FOUND;
         end
      end else if (cmd.step) begin
         rsp_status_ff <= ST_FIRED;
         rsp_id_ff     <= ID_OUT_W'(walk_inc);
         rsp_tag_ff    <= tag_ff[walk_ff];
         rsp_last_ff   <= 1'b0;
      end else begin
         rsp_status_ff <= ST_TICK_DONE;
      end
   end

   assign rsp_strobe           = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_timer_id_res     = rsp_id_ff;
   assign rsp_callback_tag_res = rsp_tag_ff;
   assign rsp_last             = rsp_last_ff;

endmodule

// ===== src/oneshot_periodic_timer_table_unit.sv =====
`timescale 1ns / 1ps
// Timer table top level: optt_ctrl sequencer plus optt_dp slot datapath.
// Create/cancel: busy stays low, result in the cycle after the transfer, one per cycle when idle.
// Tick: busy while walking the used slots, one slot per cycle, then for the done state; only
// the done state when disabled or empty; at most one fired result per cycle, then a done result.
// Reset clears all slots as unused, enable set to 1; receiver cannot stall.
module oneshot_periodic_timer_table_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic [optt_pkg::IV_W-1:0]         req_interval_ms,
   input  logic [optt_pkg::TAG_W-1:0]        req_callback_tag,
   input  logic [optt_pkg::ID_IN_W-1:0]      req_timer_id,
   input  logic [optt_pkg::TICK_W-1:0]       req_tick_ms,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_enable,
   output logic                              rsp_strobe,
   output logic [2:0]                        rsp_status,
   output logic [optt_pkg::ID_OUT_W-1:0]     rsp_timer_id_res,
   output logic [optt_pkg::TAG_W-1:0]        rsp_callback_tag_res,
   output logic                              rsp_last
);
   import optt_pkg::*;

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   optt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   optt_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_type             (req_type),
      .req_interval_ms      (req_interval_ms),
      .req_callback_tag     (req_callback_tag),
      .req_timer_id         (req_timer_id),
      .req_tick_ms          (req_tick_ms),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_enable           (csr_enable),
      .rsp_strobe           (rsp_strobe),
      .rsp_status           (rsp_status),
      .rsp_timer_id_res     (rsp_timer_id_res),
      .rsp_callback_tag_res (rsp_callback_tag_res),
      .rsp_last             (rsp_last)
   );

endmodule
